// ----- rtl/assert_macros.svh -----
// Assertion macros shared by the RTL; they expand to nothing when SYNTH is set.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// The condition must hold at every clock edge once out of reset.
`define ASSERT_ALWAYS(lbl, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("assertion failed");

// Whenever ante holds, cons must hold in the same cycle.
`define ASSERT_IMPLIES(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

`else

`define ASSERT_ALWAYS(lbl, cond)
`define ASSERT_IMPLIES(lbl, ante, cons)

`endif

`endif

// ----- rtl/tkm_pkg.sv -----
// Package: constants, codes and structs for the tick timebase / key / motor core.
package tkm_pkg;

    localparam int BASE_WRAP      = 100000;
    localparam int SECOND_DIVIDER = 100;
    localparam int INPUT_WRAP     = 3000;

    localparam int KIND_W   = 2;
    localparam int KEY_W    = 16;
    localparam int MOTOR_W  = 16;
    localparam int TIME_W   = 12;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;

    localparam int BASE_W = $clog2(BASE_WRAP + 1);
    localparam int SEC_W  = (SECOND_DIVIDER > 1) ? $clog2(SECOND_DIVIDER) : 1;
    localparam int IN_CNT_W = ($clog2(INPUT_WRAP + 1) > TIME_W) ?
                              $clog2(INPUT_WRAP + 1) : TIME_W;

    localparam logic [KIND_W-1:0] KIND_TICK  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_START = 2'd1;
    localparam logic [KIND_W-1:0] KIND_STOP  = 2'd2;
    localparam logic [KIND_W-1:0] KIND_READ  = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_KEY_VALID   = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MOTOR_PULSE = 1'd1;

    localparam logic [KEY_W-1:0] KEY_VALID_RESET   = 16'd5;
    localparam logic [MOTOR_W-1:0] MOTOR_PULSE_RESET = 16'd10;
    localparam logic [KEY_W-1:0] KEY_HOLD_MAX      = '1;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic              key_level;
    } item_t;

    typedef struct packed {
        logic              second_pulse;
        logic              key_event;
        logic              motor_drive;
        logic [TIME_W-1:0] input_time_value;
    } result_t;

    typedef struct packed {
        logic [BASE_W-1:0]   base_count;
        logic [SEC_W-1:0]    sec_residue;
        logic [IN_CNT_W-1:0] input_count;
    } status_t;

endpackage

// ----- rtl/tkm_in_stage.sv -----
// Input register: holds one accepted transaction until the update stage takes it.
module tkm_in_stage (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic [tkm_pkg::KIND_W-1:0] kind,
    input  logic                     key_level,
    input  logic                     advance,
    output logic                     stage_valid,
    output tkm_pkg::item_t           stage_item
);

    logic           valid_reg;
    logic           valid_next;
    tkm_pkg::item_t item_reg;

    assign in_ready    = !valid_reg || advance;
    assign stage_valid = valid_reg;
    assign stage_item  = item_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (in_valid && in_ready)
        begin
            valid_next = 1'b1;
        end
        else if (advance)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Payload needs no reset: load on accept only.
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg.kind      <= kind;
            item_reg.key_level <= key_level;
        end
    end

endmodule

// ----- rtl/tkm_tick_unit.sv -----
// Update logic: configuration, counters and key/motor state, one item per step.
module tkm_tick_unit (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [tkm_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [tkm_pkg::CFG_DATA_W-1:0] cfg_wdata,
    input  logic                           step,
    input  tkm_pkg::item_t                 item,
    output tkm_pkg::result_t               result,
    output tkm_pkg::status_t               status
);

    logic [tkm_pkg::KEY_W-1:0]    key_valid_reg;
    logic [tkm_pkg::MOTOR_W-1:0]  motor_pulse_reg;

    logic [tkm_pkg::BASE_W-1:0]   base_count_reg,  base_count_next;
    logic [tkm_pkg::SEC_W-1:0]    sec_residue_reg, sec_residue_next;
    logic                         input_running_reg, input_running_next;
    logic [tkm_pkg::IN_CNT_W-1:0] input_count_reg, input_count_next;
    logic [tkm_pkg::MOTOR_W-1:0]  motor_count_reg, motor_count_next;
    logic                         motor_level_reg, motor_level_next;
    logic [tkm_pkg::KEY_W-1:0]    key_hold_reg,    key_hold_next;
    logic                         key_event;

    always_comb
    begin
        base_count_next    = base_count_reg;
        sec_residue_next   = sec_residue_reg;
        input_running_next = input_running_reg;
        input_count_next   = input_count_reg;
        motor_count_next   = motor_count_reg;
        motor_level_next   = motor_level_reg;
        key_hold_next      = key_hold_reg;
        key_event          = 1'b0;

        case (item.kind)
            tkm_pkg::KIND_TICK:
            begin
                // Residue tracks base_count modulo the second divider.
                if (base_count_reg < tkm_pkg::BASE_W'(tkm_pkg::BASE_WRAP))
                begin
                    base_count_next = base_count_reg + 1'b1;
                    if (sec_residue_reg == tkm_pkg::SEC_W'(tkm_pkg::SECOND_DIVIDER - 1))
                    begin
                        sec_residue_next = '0;
                    end
                    else
                    begin
                        sec_residue_next = sec_residue_reg + 1'b1;
                    end
                end
                else
                begin
                    base_count_next  = '0;
                    sec_residue_next = '0;
                end

                if (input_running_reg)
                begin
                    if (input_count_reg < tkm_pkg::IN_CNT_W'(tkm_pkg::INPUT_WRAP))
                    begin
                        input_count_next = input_count_reg + 1'b1;
                    end
                    else
                    begin
                        input_count_next = '0;
                    end
                end

                if (motor_count_reg != '0)
                begin
                    motor_count_next = motor_count_reg - 1'b1;
                    motor_level_next = (motor_count_reg != tkm_pkg::MOTOR_W'(1));
                end

                if (!item.key_level)
                begin
                    if (key_hold_reg != tkm_pkg::KEY_HOLD_MAX)
                    begin
                        key_hold_next = key_hold_reg + 1'b1;
                    end
                end
                else
                begin
                    // Release: long enough hold loads a fresh motor pulse.
                    if (key_hold_reg > key_valid_reg)
                    begin
                        key_event        = 1'b1;
                        motor_count_next = motor_pulse_reg;
                    end
                    key_hold_next = '0;
                end
            end
            tkm_pkg::KIND_START:
            begin
                input_running_next = 1'b1;
                input_count_next   = '0;
            end
            tkm_pkg::KIND_STOP:
            begin
                input_running_next = 1'b0;
                input_count_next   = '0;
            end
            default:
            begin
                // Read: no state change.
            end
        endcase
    end

    assign result.second_pulse     = (item.kind == tkm_pkg::KIND_TICK) &&
                                     (sec_residue_next == '0);
    assign result.key_event        = key_event;
    assign result.motor_drive      = motor_level_next;
    assign result.input_time_value = input_count_next[tkm_pkg::TIME_W-1:0];

    assign status.base_count  = base_count_reg;
    assign status.sec_residue = sec_residue_reg;
    assign status.input_count = input_count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_valid_reg   <= tkm_pkg::KEY_VALID_RESET;
            motor_pulse_reg <= tkm_pkg::MOTOR_PULSE_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                tkm_pkg::CFG_KEY_VALID:   key_valid_reg   <= cfg_wdata;
                tkm_pkg::CFG_MOTOR_PULSE: motor_pulse_reg <= cfg_wdata;
                default:                  ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_count_reg    <= '0;
            sec_residue_reg   <= '0;
            input_running_reg <= 1'b0;
            input_count_reg   <= '0;
            motor_count_reg   <= '0;
            motor_level_reg   <= 1'b0;
            key_hold_reg      <= '0;
        end
        else if (step)
        begin
            base_count_reg    <= base_count_next;
            sec_residue_reg   <= sec_residue_next;
            input_running_reg <= input_running_next;
            input_count_reg   <= input_count_next;
            motor_count_reg   <= motor_count_next;
            motor_level_reg   <= motor_level_next;
            key_hold_reg      <= key_hold_next;
        end
    end

endmodule

// ----- rtl/tkm_out_stage.sv -----
// Result register: holds one result transaction until the consumer takes it.
module tkm_out_stage (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             load_valid,
    input  tkm_pkg::result_t load_result,
    output logic             take,
    output logic             out_valid,
    input  logic             out_ready,
    output tkm_pkg::result_t out_result
);

    logic             valid_reg;
    tkm_pkg::result_t result_reg;

    // Take a new result when empty or when the held one leaves this cycle.
    assign take       = load_valid && (!valid_reg || out_ready);
    assign out_valid  = valid_reg;
    assign out_result = result_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (take)
        begin
            valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            result_reg <= load_result;
        end
    end

endmodule

// ----- rtl/tick_timebase_key_motor_core.sv -----
// Top level of the tick timebase, key-press detector and motor pulse core.
//
//  channel   direction  handshake             payload
//  in        sink       in_valid / in_ready   kind, key_level
//  out       source     out_valid / out_ready second_pulse, key_event, motor_drive,
//                                             input_time_value
//  cfg       sink       cfg_we (no wait)      cfg_index, cfg_wdata
//
// One transaction per cycle sustained while out_ready stays high; an accepted input
// passes through the input register, then the update logic into the result register.
// Non-config state updates in one update stage as an item leaves the input register.
// A stalled output holds its result; the input register still takes one more item.
// Asynchronous active-low reset clears both stage valids, all counters, and loads
// the configuration defaults (key_valid_ticks 5, motor_pulse_ticks 10).
`include "assert_macros.svh"

module tick_timebase_key_motor_core (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [tkm_pkg::KIND_W-1:0]     kind,
    input  logic                           key_level,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic                           second_pulse,
    output logic                           key_event,
    output logic                           motor_drive,
    output logic [tkm_pkg::TIME_W-1:0]     input_time_value,
    input  logic                           cfg_we,
    input  logic [tkm_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [tkm_pkg::CFG_DATA_W-1:0] cfg_wdata
);

    logic             stage_valid;
    logic             advance;
    tkm_pkg::item_t   stage_item;
    tkm_pkg::result_t step_result;
    tkm_pkg::result_t out_result;
    tkm_pkg::status_t status;

    // Input register: accept while empty or draining this cycle.
    tkm_in_stage u_in_stage (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .kind        (kind),
        .key_level   (key_level),
        .advance     (advance),
        .stage_valid (stage_valid),
        .stage_item  (stage_item)
    );

    // Update logic: commit state exactly when the item moves to the result register.
    tkm_tick_unit u_tick_unit (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .step      (advance),
        .item      (stage_item),
        .result    (step_result),
        .status    (status)
    );

    // Result register: decouple the consumer from the update stage.
    tkm_out_stage u_out_stage (
        .clk         (clk),
        .rst_n       (rst_n),
        .load_valid  (stage_valid),
        .load_result (step_result),
        .take        (advance),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_result  (out_result)
    );

    assign second_pulse     = out_result.second_pulse;
    assign key_event        = out_result.key_event;
    assign motor_drive      = out_result.motor_drive;
    assign input_time_value = out_result.input_time_value;

    // Counters never pass their wrap points; residue is zero whenever the base is.
    `ASSERT_ALWAYS(a_base_in_range, status.base_count <= tkm_pkg::BASE_W'(tkm_pkg::BASE_WRAP))
    `ASSERT_ALWAYS(a_input_in_range, status.input_count <= tkm_pkg::IN_CNT_W'(tkm_pkg::INPUT_WRAP))
    `ASSERT_IMPLIES(a_residue_zero, status.base_count == '0, status.sec_residue == '0)
    // Input side stalls only with a full input register that cannot drain.
    `ASSERT_IMPLIES(a_stall_cause, !in_ready, stage_valid && out_valid && !out_ready)

endmodule
